@@ sv/tqfba_pkg.sv @@
// shared types, constants and codes for the two-queue flush batch arbiter
// no dependencies; imported by every module of the block
package tqfba_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned MAX_BATCH_DEF   = 16;

  localparam int unsigned TAG_W      = 32;
  localparam int unsigned BSZ_W      = 5;
  localparam int unsigned BURST_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [BSZ_W-1:0]   BATCH_SIZE_RST  = 5'd8;
  localparam logic [BURST_W-1:0] BURST_LIMIT_RST = 8'd4;
  localparam logic [BURST_W-1:0] STREAK_MAX      = 8'hFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPPING    = 2'd2;

  // input kinds
  localparam logic KIND_ENQ   = 1'b0;
  localparam logic KIND_BATCH = 1'b1;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_STOP  = 2'd2,
    STS_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_PICK,
    S_GRANT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;      // input beat taken this cycle
    logic pick;        // choose a queue, pop it and read its head
    logic load_res;    // move the pending single result to the output
    logic load_grant;  // move the fetched grant to the output
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic all_empty;   // both queues hold nothing
    logic out_free;    // output register can take a beat this cycle
    logic grant_last;  // fetched grant closes the batch
  } sts_t;

endpackage

@@ sv/tqfba_ctrl.sv @@
// sequencing state machine of the flush batch arbiter
// depends on tqfba_pkg; drives tqfba_dp through cmd_t, watches sts_t
module tqfba_ctrl
  import tqfba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_BATCH && !sts.all_empty) begin
            state_nxt = S_PICK;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_PICK: begin
        state_nxt = S_GRANT;
      end
      S_GRANT: begin
        if (sts.out_free) begin
          state_nxt = sts.grant_last ? S_IDLE : S_PICK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_RESP:  cmd.load_res   = sts.out_free;
      S_PICK:  cmd.pick       = 1'b1;
      S_GRANT: cmd.load_grant = sts.out_free;
      default: cmd            = '0;
    endcase
  end

endmodule

@@ sv/tqfba_dp.sv @@
// datapath: config registers, two tag queues in memories, streak counter,
// grant selection and output register; depends on tqfba_pkg
module tqfba_dp
  import tqfba_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_BATCH   = MAX_BATCH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_kind,
  input  logic [TAG_W-1:0]      in_tag,
  input  logic                  in_bg,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output status_t               out_status,
  output logic [TAG_W-1:0]      out_tag,
  output logic                  out_bg,
  output logic                  out_last
);

  localparam int unsigned AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NW0 = $clog2(MAX_BATCH + 1);
  localparam int unsigned CW  = (NW0 > BSZ_W) ? NW0 : BSZ_W;
  localparam logic [AW-1:0]  HEAD_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [AW:0]    DEPTH_W   = (AW+1)'(QUEUE_DEPTH);
  localparam logic [QCW-1:0] QFULL     = QCW'(QUEUE_DEPTH);
  localparam logic [CW-1:0]  MAXB      = CW'(MAX_BATCH);

  // configuration
  logic [BSZ_W-1:0]   batch_size_r;
  logic [BURST_W-1:0] burst_limit_r;
  logic               stopping_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_size_r  <= BATCH_SIZE_RST;
      burst_limit_r <= BURST_LIMIT_RST;
      stopping_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BATCH_SIZE:  batch_size_r  <= cfg_wdata[BSZ_W-1:0];
        CFG_BURST_LIMIT: burst_limit_r <= cfg_wdata[BURST_W-1:0];
        CFG_STOPPING:    stopping_r    <= cfg_wdata[0];
        default:         ;
      endcase
    end
  end

  // queue bookkeeping
  logic [AW-1:0]  fg_head_r, bg_head_r;
  logic [QCW-1:0] fg_cnt_r, bg_cnt_r;
  logic [BURST_W-1:0] streak_r;
  logic [TAG_W-1:0] fg_mem [QUEUE_DEPTH];
  logic [TAG_W-1:0] bg_mem [QUEUE_DEPTH];
  logic [TAG_W-1:0] fg_rd_r, bg_rd_r;

  logic [AW:0]   fg_sum, bg_sum;
  logic [AW-1:0] fg_tail, bg_tail;
  logic          fg_full, bg_full, enq_full;
  status_t       enq_status;
  logic          do_push, push_fg, push_bg;

  always_comb begin
    fg_sum  = (AW+1)'(fg_head_r) + (AW+1)'(fg_cnt_r);
    bg_sum  = (AW+1)'(bg_head_r) + (AW+1)'(bg_cnt_r);
    fg_tail = (fg_sum >= DEPTH_W) ? AW'(fg_sum - DEPTH_W) : fg_sum[AW-1:0];
    bg_tail = (bg_sum >= DEPTH_W) ? AW'(bg_sum - DEPTH_W) : bg_sum[AW-1:0];
    fg_full  = (fg_cnt_r == QFULL);
    bg_full  = (bg_cnt_r == QFULL);
    enq_full = in_bg ? bg_full : fg_full;
    if (stopping_r) begin
      enq_status = STS_STOP;
    end else if (enq_full) begin
      enq_status = STS_FULL;
    end else begin
      enq_status = STS_OK;
    end
    do_push = cmd.accept && (in_kind == KIND_ENQ) && (enq_status == STS_OK);
    push_fg = do_push && !in_bg;
    push_bg = do_push && in_bg;
  end

  // grant choice
  logic fg_nz, bg_nz, sel_bg, pop_fg, pop_bg;
  logic [QCW-1:0] fg_after, bg_after;

  always_comb begin
    fg_nz  = (fg_cnt_r != '0);
    bg_nz  = (bg_cnt_r != '0);
    sel_bg = (bg_nz && (streak_r >= burst_limit_r)) || !fg_nz;
    pop_fg = cmd.pick && !sel_bg;
    pop_bg = cmd.pick && sel_bg;
    fg_after = fg_cnt_r - QCW'(pop_fg);
    bg_after = bg_cnt_r - QCW'(pop_bg);
  end

  // effective batch limit
  logic [CW-1:0] lim;
  logic [CW-1:0] cnt_r;
  logic [CW:0]   cnt_inc;

  always_comb begin
    if (batch_size_r == '0) begin
      lim = CW'(1);
    end else if (CW'(batch_size_r) > MAXB) begin
      lim = MAXB;
    end else begin
      lim = CW'(batch_size_r);
    end
    cnt_inc = (CW+1)'(cnt_r) + (CW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_head_r <= '0;
      bg_head_r <= '0;
      fg_cnt_r  <= '0;
      bg_cnt_r  <= '0;
      streak_r  <= '0;
    end else begin
      fg_cnt_r <= fg_after + QCW'(push_fg);
      bg_cnt_r <= bg_after + QCW'(push_bg);
      if (pop_fg) begin
        fg_head_r <= (fg_head_r == HEAD_LAST) ? '0 : fg_head_r + AW'(1);
        if (streak_r != STREAK_MAX) begin
          streak_r <= streak_r + BURST_W'(1);
        end
      end
      if (pop_bg) begin
        bg_head_r <= (bg_head_r == HEAD_LAST) ? '0 : bg_head_r + AW'(1);
        streak_r  <= '0;
      end
    end
  end

  // tag memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (push_fg) begin
      fg_mem[fg_tail] <= in_tag;
    end
    if (pop_fg) begin
      fg_rd_r <= fg_mem[fg_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (push_bg) begin
      bg_mem[bg_tail] <= in_tag;
    end
    if (pop_bg) begin
      bg_rd_r <= bg_mem[bg_head_r];
    end
  end

  // per-item scratch
  status_t res_status_r;
  logic    gbg_r, glast_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status_r <= (in_kind == KIND_ENQ) ? enq_status : STS_EMPTY;
    end
    if (cmd.pick) begin
      gbg_r   <= sel_bg;
      glast_r <= (cnt_inc >= (CW+1)'(lim)) || (fg_after == '0 && bg_after == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cnt_r <= '0;
    end else if (cmd.pick) begin
      cnt_r <= cnt_inc[CW-1:0];
    end
  end

  // output register
  logic               out_valid_r;
  status_t            out_status_r;
  logic [TAG_W-1:0]   out_tag_r;
  logic               out_bg_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_res || cmd.load_grant) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      out_status_r <= res_status_r;
      out_tag_r    <= '0;
      out_bg_r     <= 1'b0;
      out_last_r   <= 1'b1;
    end else if (cmd.load_grant) begin
      out_status_r <= STS_OK;
      out_tag_r    <= gbg_r ? bg_rd_r : fg_rd_r;
      out_bg_r     <= gbg_r;
      out_last_r   <= glast_r;
    end
  end

  always_comb begin
    sts.all_empty  = !fg_nz && !bg_nz;
    sts.out_free   = !out_valid_r || out_ready;
    sts.grant_last = glast_r;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_tag    = out_tag_r;
  assign out_bg     = out_bg_r;
  assign out_last   = out_last_r;

endmodule

@@ sv/two_queue_flush_batch_arbiter_core.sv @@
// top level of the two-queue flush batch arbiter
// depends on tqfba_pkg, tqfba_ctrl and tqfba_dp
//
// keeps a foreground and a background queue of 32-bit flush tags. an enqueue
// beat (in_tuser[0] = 0) puts in_tdata into the queue picked by in_tuser[1]
// and answers with one beat carrying ok, queue full or shutting down; it is
// accepted while idle, then loaded into the output register once free. a
// batch beat (in_tuser[0] = 1) hands out up to batch_size tags (0 acts as 1,
// capped at MAX_BATCH), foreground first, except that a waiting background
// tag is served once the run of consecutive foreground grants has reached
// burst_limit; that run survives across batches and saturates at 255. a
// batch with both queues empty answers with one empty-marked beat. each grant
// passes a pick step (select and memory read), then a grant step (load into
// the output register once it is free), because the tag queues are memories
// with one write and one registered read port each. a new input beat is
// taken only once the previous item has placed its last result in the
// output register, which itself may still be waiting on out_tready.
// configuration goes through a plain write port and is expected while idle
module two_queue_flush_batch_arbiter_core
  import tqfba_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_BATCH   = MAX_BATCH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TAG_W-1:0]      in_tdata,   // task_tag
  input  logic [1:0]            in_tuser,   // kind, background_task
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TAG_W-1:0]      out_tdata,  // granted_tag
  output logic [2:0]            out_tuser,  // status[1:0], from_background
  output logic                  out_tlast
);

  cmd_t    cmd;
  sts_t    sts;
  status_t out_status;
  logic    out_bg;

  // state machine: accept, pick, load sequencing
  tqfba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser[0]),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // queues, arbitration and output register
  tqfba_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_BATCH   (MAX_BATCH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_kind    (in_tuser[0]),
    .in_tag     (in_tdata),
    .in_bg      (in_tuser[1]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_tag    (out_tdata),
    .out_bg     (out_bg),
    .out_last   (out_tlast)
  );

  assign out_tuser = {out_bg, out_status};

endmodule

@@ bench/tqfba_checker.sv @@
// result checker for the two-queue flush batch arbiter
// watches the configuration, input and result ports and mirrors the arbitration
// depends on tqfba_pkg
module tqfba_checker
  import tqfba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [TAG_W-1:0]      in_tdata,   // task_tag
  input  logic [1:0]            in_tuser,   // kind, background_task
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [TAG_W-1:0]      out_tdata,  // granted_tag
  input  logic [2:0]            out_tuser,  // status[1:0], from_background
  input  logic                  out_tlast,
  output int                    responses_due,
  output int                    mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TQ_AW   = $clog2(QUEUE_DEPTH_DEF);
  localparam int unsigned RESP_AW = 5;   // one full batch plus a waiting beat fits

  typedef struct packed {
    status_t          status;
    logic [TAG_W-1:0] tag;
    logic             from_bg;
    logic             last;
  } response_t;

  response_t          resp_ring[2**RESP_AW];
  logic [RESP_AW-1:0] resp_rd;
  int                 resp_cnt;
  logic [TAG_W-1:0]   fg_tags[QUEUE_DEPTH_DEF];
  logic [TAG_W-1:0]   bg_tags[QUEUE_DEPTH_DEF];
  logic [TQ_AW-1:0]   fg_rd, bg_rd;
  int                 fg_cnt, bg_cnt;
  logic [BURST_W-1:0] fg_streak;
  logic [BSZ_W-1:0]   batch_size;
  logic [BURST_W-1:0] burst_limit;
  logic               stopping;

  // one owed reply beat at the tail of the ring
  task automatic resp_add(input response_t r);
    logic [RESP_AW-1:0] wr;
    wr = resp_rd + RESP_AW'(resp_cnt);
    resp_ring[wr] = r;
    resp_cnt++;
  endtask

  // tag into the tail of the chosen queue
  task automatic tag_store(input logic to_bg, input logic [TAG_W-1:0] tag);
    logic [TQ_AW-1:0] wr;
    if (to_bg) begin
      wr = bg_rd + TQ_AW'(bg_cnt);
      bg_tags[wr] = tag;
      bg_cnt++;
    end else begin
      wr = fg_rd + TQ_AW'(fg_cnt);
      fg_tags[wr] = tag;
      fg_cnt++;
    end
  endtask

  // oldest tag out of the chosen queue
  task automatic tag_take(input logic from_bg, output logic [TAG_W-1:0] tag);
    if (from_bg) begin
      tag   = bg_tags[bg_rd];
      bg_rd = bg_rd + 1'b1;
      bg_cnt--;
    end else begin
      tag   = fg_tags[fg_rd];
      fg_rd = fg_rd + 1'b1;
      fg_cnt--;
    end
  endtask

  // one accepted beat: queue the reply beats the arbiter owes for it
  task automatic serve_item(input logic kind, input logic [TAG_W-1:0] tag,
                            input logic to_bg);
    int unsigned      limit;
    int unsigned      n;
    logic             take_bg;
    logic             closing;
    logic [TAG_W-1:0] granted;
    if (kind == KIND_ENQ) begin
      if (stopping) begin
        resp_add(response_t'{STS_STOP, '0, 1'b0, 1'b1});
      end else if ((to_bg ? bg_cnt : fg_cnt) >= int'(QUEUE_DEPTH_DEF)) begin
        resp_add(response_t'{STS_FULL, '0, 1'b0, 1'b1});
      end else begin
        tag_store(to_bg, tag);
        resp_add(response_t'{STS_OK, '0, 1'b0, 1'b1});
      end
    end else if (fg_cnt == 0 && bg_cnt == 0) begin
      resp_add(response_t'{STS_EMPTY, '0, 1'b0, 1'b1});
    end else begin
      limit = (batch_size == 0) ? 1 :
              (batch_size > MAX_BATCH_DEF) ? MAX_BATCH_DEF : batch_size;
      n = 0;
      while (n < limit && (fg_cnt != 0 || bg_cnt != 0)) begin
        // background wins once the foreground run has hit the limit
        take_bg = bg_cnt != 0 && (fg_streak >= burst_limit || fg_cnt == 0);
        tag_take(take_bg, granted);
        if (take_bg) begin
          fg_streak = '0;
        end else begin
          if (fg_streak != STREAK_MAX) fg_streak = fg_streak + 1'b1;
        end
        n++;
        closing = (n == limit) || (fg_cnt == 0 && bg_cnt == 0);
        resp_add(response_t'{STS_OK, granted, take_bg, closing});
      end
    end
  endtask

  always @(posedge clk) begin
    response_t want;
    if (!rst_n) begin
      resp_rd        = '0;
      resp_cnt       = 0;
      fg_rd          = '0;
      bg_rd          = '0;
      fg_cnt         = 0;
      bg_cnt         = 0;
      fg_streak      = '0;
      batch_size     = BATCH_SIZE_RST;
      burst_limit    = BURST_LIMIT_RST;
      stopping       = 1'b0;
      mismatch_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (resp_cnt == 0) begin
          $display("%0t: unexpected result beat, got status %0d tag %h bg %b last %b",
                   $time, out_tuser[1:0], out_tdata, out_tuser[2], out_tlast);
          mismatch_count++;
        end else begin
          want    = resp_ring[resp_rd];
          resp_rd = resp_rd + 1'b1;
          resp_cnt--;
          if (out_tuser[1:0] !== want.status || out_tdata !== want.tag ||
              out_tuser[2] !== want.from_bg || out_tlast !== want.last) begin
            $display("%0t: result mismatch, expected status %0d tag %h bg %b last %b",
                     $time, want.status, want.tag, want.from_bg, want.last);
            $display("%0t:                  got      status %0d tag %h bg %b last %b",
                     $time, out_tuser[1:0], out_tdata, out_tuser[2], out_tlast);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BATCH_SIZE:  batch_size  = cfg_wdata[BSZ_W-1:0];
          CFG_BURST_LIMIT: burst_limit = cfg_wdata[BURST_W-1:0];
          CFG_STOPPING:    stopping    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) serve_item(in_tuser[0], in_tdata, in_tuser[1]);
    end
    responses_due = resp_cnt;
  end

endmodule

@@ bench/tb_two_queue_flush_batch_arbiter_core.sv @@
// testbench top for the two-queue flush batch arbiter: clock, reset, stimulus
// and verdict; checking is done by tqfba_checker
// depends on tqfba_pkg, tqfba_checker and two_queue_flush_batch_arbiter_core
module tb_two_queue_flush_batch_arbiter_core;
  import tqfba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RX_STALL_CYCLES = 400;   // long hold-off on the result side
  localparam int DRAIN_CYCLES    = 40;    // quiet stretch before the verdict

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TAG_W-1:0]      in_tdata;   // task_tag
  logic [1:0]            in_tuser;   // kind, background_task
  logic                  out_tvalid;
  logic                  out_tready;
  logic [TAG_W-1:0]      out_tdata;  // granted_tag
  logic [2:0]            out_tuser;  // status[1:0], from_background
  logic                  out_tlast;

  int responses_due;
  int mismatch_count;
  int cycle_count = 0;
  int stall_asks;    // bumped by the stimulus, served by the receiver

  two_queue_flush_batch_arbiter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  tqfba_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .responses_due  (responses_due),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake or a missing result ends up here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // idle length before a beat: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // present one input beat and hold it until the block takes it; tready is
  // looked at on the falling edge so the decision never races the block
  task automatic offer(input logic kind, input logic [TAG_W-1:0] tag,
                       input logic to_bg);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= tag;
    in_tuser  <= {to_bg, kind};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  // stop sending, wait for every owed result, then let the block sit quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (responses_due != 0);
    repeat (4) @(posedge clk);
  endtask

  // all three registers in back-to-back writes, only ever called while idle
  task automatic set_config(input int bsz, input int burst, input int stop);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BATCH_SIZE;
    cfg_wdata <= CFG_DATA_W'(bsz);
    @(posedge clk);
    cfg_index <= CFG_BURST_LIMIT;
    cfg_wdata <= CFG_DATA_W'(burst);
    @(posedge clk);
    cfg_index <= CFG_STOPPING;
    cfg_wdata <= CFG_DATA_W'(stop);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // rounds of enqueues closed by a batch request, with a stray batch now
  // and then in the middle of a round
  task automatic run_rounds(input int bg_pct, input int rounds,
                            input int min_enq, input int max_enq);
    int n;
    for (int rd = 0; rd < rounds; rd++) begin
      n = $urandom_range(min_enq, max_enq);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 8)
          offer(KIND_BATCH, $urandom(), 1'($urandom_range(0, 1)));
        offer(KIND_ENQ, $urandom(), $urandom_range(0, 99) < bg_pct);
      end
      offer(KIND_BATCH, $urandom(), 1'($urandom_range(0, 1)));
    end
  endtask

  // result side: random tready with long and short gaps, full-speed
  // stretches, and the long hold-off whenever the stimulus asks for one
  initial begin
    int stalls_served;
    int r;
    stalls_served = 0;
    forever begin
      if (stall_asks != stalls_served) begin
        stalls_served++;
        out_tready <= 1'b0;
        repeat (RX_STALL_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end else if (r < 85) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (r < 93) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(8, 40)) @(posedge clk);
        end else begin
          out_tready <= 1'b1;
          repeat ($urandom_range(30, 90)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_BATCH_SIZE;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    stall_asks <= 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset settings: batch 8, burst limit 4, running
    offer(KIND_BATCH, '0, 1'b0);                 // both queues empty
    offer(KIND_ENQ, 32'h0000_0000, 1'b0);        // tag extremes, both queues
    offer(KIND_ENQ, 32'hFFFF_FFFF, 1'b0);
    offer(KIND_ENQ, 32'hA5A5_A5A5, 1'b1);
    offer(KIND_ENQ, 32'h5A5A_5A5A, 1'b1);
    offer(KIND_BATCH, 32'hFFFF_FFFF, 1'b1);      // foreground, then background
    // fill the foreground queue and push one beyond it
    for (int i = 0; i < QUEUE_DEPTH_DEF + 1; i++)
      offer(KIND_ENQ, $urandom(), 1'b0);
    settle();
    // shutting down: rejected before the full check, batches still drain
    set_config(8, 4, 1);
    offer(KIND_ENQ, $urandom(), 1'b0);
    offer(KIND_ENQ, $urandom(), 1'b1);
    offer(KIND_BATCH, $urandom(), 1'b0);
    settle();

    // reset-like settings, with the receiver holding off early on so the
    // output register and the input side back up
    set_config(8, 4, 0);
    stall_asks <= stall_asks + 1;
    run_rounds(40, 4, 0, 10);
    settle();

    // one tag per batch, zero burst limit: background always first
    set_config(1, 0, 0);
    run_rounds(50, 4, 0, 10);
    settle();

    // largest batch and burst limit: empty both queues first, then a long
    // foreground-only run drives the streak to saturation
    set_config(16, 255, 0);
    offer(KIND_BATCH, $urandom(), 1'b0);
    offer(KIND_BATCH, $urandom(), 1'b1);
    run_rounds(0, 17, 15, 17);
    // saturated streak meets the limit, so background cuts in
    run_rounds(30, 3, 0, 10);
    settle();

    // batch size 0 behaves as 1
    set_config(0, 2, 0);
    run_rounds(50, 3, 0, 10);
    settle();

    // batch size above the maximum is capped
    set_config(31, 1, 0);
    run_rounds(50, 3, 0, 12);
    settle();

    // shutting down with leftovers from before
    set_config(17, 3, 1);
    run_rounds(50, 3, 0, 10);
    settle();

    // small batches against heavy background traffic, fills that queue
    set_config(5, 7, 0);
    run_rounds(60, 3, 0, 16);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
sv/tqfba_pkg.sv
sv/tqfba_ctrl.sv
sv/tqfba_dp.sv
sv/two_queue_flush_batch_arbiter_core.sv
bench/tqfba_checker.sv
bench/tb_two_queue_flush_batch_arbiter_core.sv
